>>> rtl/dhte_pkg.sv
// Shared types and codes for the double hashing table engine.
// Used by dhte_probe_eval and double_hash_table_engine; no dependencies.
package dhte_pkg;

    // Field widths fixed by the interface
    localparam int OPCODE_W   = 2;
    localparam int KEY_W      = 64;
    localparam int TAG_W      = 8;
    localparam int HANDLE_W   = 16;
    localparam int STATUS_W   = 2;
    localparam int SLOT_IDX_W = 10;
    localparam int COUNT_W    = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;
    localparam int KIND_W     = 2;

    // Probe stride: key bits STRIDE_LSB upwards, STRIDE_W wide, forced odd
    localparam int STRIDE_LSB = 9;
    localparam int STRIDE_W   = 8;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0]  REG_LOAD_LIMIT     = 1'd0;
    localparam logic [CFG_IDX_W-1:0]  REG_REPACK_LIMIT   = 1'd1;
    localparam logic [CFG_DATA_W-1:0] LOAD_LIMIT_RESET   = 11'd800;
    localparam logic [CFG_DATA_W-1:0] REPACK_LIMIT_RESET = 11'd600;

    // Request opcodes
    localparam logic [OPCODE_W-1:0] OP_FIND   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_STORE  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUP     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    // Slot kinds
    localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LIVE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DELETED = 2'd2;

    // One slot as held in the table memory
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [KEY_W-1:0]    key;
        logic [TAG_W-1:0]    tag;
        logic [HANDLE_W-1:0] handle;
    } slot_word_t;

    localparam int SLOT_WORD_W = $bits(slot_word_t);

    // Decision for one probed slot, from the compare unit to the sequencer
    typedef struct packed {
        logic                stop;       // probe ends at this slot
        logic [STATUS_W-1:0] status;     // status when stopping here
        logic [STATUS_W-1:0] exhausted;  // status if the probe runs out
        logic                wr;         // rewrite this slot
        logic [KIND_W-1:0]   wr_kind;    // new kind of the slot
        logic                locate;     // report this slot's index
        logic                report;     // report type tag and handle
        logic                inc_live;
        logic                dec_live;
    } probe_dec_t;

endpackage

>>> rtl/double_hash_table_engine.sv
// Double hashing table engine: sequencer, counters and table memory.
// Depends on dhte_pkg, dhte_ram and dhte_probe_eval.
//
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_opcode, s_key, s_type_tag, s_handle
// m_        out        m_valid / m_ready  m_status, m_slot_index, m_found_type,
//                                         m_found_handle, m_live_count, m_repack_due
// cfg_      in         cfg_we             cfg_index, cfg_wdata
//
// A request is taken in idle and then probes 1 to TABLE_SLOTS slots, one after another,
// each through the registered read of the single table memory port feeding the compare unit.
// After reset a clearing pass writes every slot empty, with s_ready low until it ends.
// Only one request is in flight; s_ready is high in idle even while a result waits.
// A finished probe holds its last slot until the result register is free.
module double_hash_table_engine
    import dhte_pkg::*;
#(
    parameter int TABLE_SLOTS = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // request channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [OPCODE_W-1:0]   s_opcode,
    input  logic [KEY_W-1:0]      s_key,
    input  logic [TAG_W-1:0]      s_type_tag,
    input  logic [HANDLE_W-1:0]   s_handle,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STATUS_W-1:0]   m_status,
    output logic [SLOT_IDX_W-1:0] m_slot_index,
    output logic [TAG_W-1:0]      m_found_type,
    output logic [HANDLE_W-1:0]   m_found_handle,
    output logic [COUNT_W-1:0]    m_live_count,
    output logic                  m_repack_due,
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int IDX_W   = $clog2(TABLE_SLOTS);
    localparam int CNT_W   = IDX_W + 1;
    localparam int CMP_W   = (CNT_W > CFG_DATA_W) ? CNT_W : CFG_DATA_W;
    localparam int OUT_C_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int OUT_S_W = (IDX_W > SLOT_IDX_W) ? IDX_W : SLOT_IDX_W;
    localparam int SUM_W   = IDX_W + STRIDE_W;

    // sequencer states
    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_PROBE = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [IDX_W-1:0]      clr_reg, clr_next;
    logic [CFG_DATA_W-1:0] load_limit_reg, repack_limit_reg;
    logic [CNT_W-1:0]      live_reg, live_next;
    logic [CNT_W-1:0]      del_reg, del_next;

    // pending request
    logic [OPCODE_W-1:0]   op_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [TAG_W-1:0]      tag_reg;
    logic [HANDLE_W-1:0]   hdl_reg;
    logic [STRIDE_W-1:0]   stride_reg;
    logic [IDX_W-1:0]      slot_reg, slot_next;
    logic [IDX_W-1:0]      probe_cnt_reg, probe_cnt_next;

    // result register
    logic                  m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [IDX_W-1:0]      where_reg, where_next;
    logic [TAG_W-1:0]      ftype_reg, ftype_next;
    logic [HANDLE_W-1:0]   fhdl_reg, fhdl_next;
    logic                  repack_reg, repack_next;

    // memory and compare unit
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr, ram_raddr;
    slot_word_t            ram_wdata, ram_rdata;
    probe_dec_t            dec;
    logic                  load_full;

    logic                  accept;
    logic                  out_free;
    logic                  last_probe;
    logic                  advance;
    logic                  finish;
    logic [IDX_W-1:0]      slot_adv;
    logic [SUM_W-1:0]      slot_sum;

    assign accept     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign last_probe = &probe_cnt_reg;
    assign load_full  = CMP_W'(live_reg) >= CMP_W'(load_limit_reg);

    // next slot on the probe path, wrapping round the table
    assign slot_sum = SUM_W'(slot_reg) + SUM_W'(stride_reg);
    assign slot_adv = slot_sum[IDX_W-1:0];

    dhte_ram #(
        .WIDTH (SLOT_WORD_W),
        .DEPTH (TABLE_SLOTS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    dhte_probe_eval u_eval (
        .opcode    (op_reg),
        .key       (key_reg),
        .type_tag  (tag_reg),
        .handle    (hdl_reg),
        .load_full (load_full),
        .slot      (ram_rdata),
        .dec       (dec)
    );

    // sequencer
    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        slot_next      = slot_reg;
        probe_cnt_next = probe_cnt_reg;
        live_next      = live_reg;
        del_next       = del_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        status_next    = status_reg;
        where_next     = where_reg;
        ftype_next     = ftype_reg;
        fhdl_next      = fhdl_reg;
        repack_next    = repack_reg;
        ram_we         = 1'b0;
        ram_waddr      = slot_reg;
        ram_wdata      = ram_rdata;
        ram_raddr      = slot_reg;
        advance        = 1'b0;
        finish         = 1'b0;

        unique case (state_reg)
            S_CLEAR: begin
                ram_we         = 1'b1;
                ram_waddr      = clr_reg;
                ram_wdata      = '0;
                ram_wdata.kind = KIND_EMPTY;
                clr_next       = clr_reg + 1'b1;
                if (&clr_reg) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                // home slot read straight from the request
                ram_raddr = s_key[IDX_W-1:0];
                if (accept) begin
                    slot_next      = s_key[IDX_W-1:0];
                    probe_cnt_next = '0;
                    state_next     = S_PROBE;
                end
            end
            S_PROBE: begin
                advance = !dec.stop && !last_probe;
                finish  = (dec.stop || last_probe) && out_free;
                if (advance) begin
                    ram_raddr      = slot_adv;
                    slot_next      = slot_adv;
                    probe_cnt_next = probe_cnt_reg + 1'b1;
                end
                if (finish) begin
                    ram_we         = dec.stop && dec.wr;
                    ram_wdata.kind = dec.wr_kind;
                    if (dec.wr_kind == KIND_LIVE) begin
                        ram_wdata.key    = key_reg;
                        ram_wdata.tag    = tag_reg;
                        ram_wdata.handle = hdl_reg;
                    end
                    if (dec.stop && dec.inc_live) begin
                        live_next = live_reg + 1'b1;
                    end
                    if (dec.stop && dec.dec_live) begin
                        if (live_reg != '0) begin
                            live_next = live_reg - 1'b1;
                        end
                        del_next = del_reg + 1'b1;
                    end
                    m_valid_next = 1'b1;
                    status_next  = dec.stop ? dec.status : dec.exhausted;
                    where_next   = (dec.stop && dec.locate) ? slot_reg : '0;
                    ftype_next   = (dec.stop && dec.report) ? ram_rdata.tag : '0;
                    fhdl_next    = (dec.stop && dec.report) ? ram_rdata.handle : '0;
                    repack_next  = CMP_W'(del_next) > CMP_W'(repack_limit_reg);
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_CLEAR;
            clr_reg          <= '0;
            live_reg         <= '0;
            del_reg          <= '0;
            m_valid_reg      <= 1'b0;
            load_limit_reg   <= LOAD_LIMIT_RESET;
            repack_limit_reg <= REPACK_LIMIT_RESET;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            live_reg    <= live_next;
            del_reg     <= del_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_LOAD_LIMIT:   load_limit_reg   <= cfg_wdata;
                    REG_REPACK_LIMIT: repack_limit_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // request and result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg     <= s_opcode;
            key_reg    <= s_key;
            tag_reg    <= s_type_tag;
            hdl_reg    <= s_handle;
            stride_reg <= s_key[STRIDE_LSB +: STRIDE_W] | STRIDE_W'(1);
        end
        slot_reg      <= slot_next;
        probe_cnt_reg <= probe_cnt_next;
        status_reg    <= status_next;
        where_reg     <= where_next;
        ftype_reg     <= ftype_next;
        fhdl_reg      <= fhdl_next;
        repack_reg    <= repack_next;
    end

    logic [OUT_C_W-1:0] live_out;
    logic [OUT_S_W-1:0] where_out;

    // live count and slot index truncated or widened to the port widths
    assign live_out  = OUT_C_W'(live_reg);
    assign where_out = OUT_S_W'(where_reg);

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_slot_index   = where_out[SLOT_IDX_W-1:0];
    assign m_found_type   = ftype_reg;
    assign m_found_handle = fhdl_reg;
    assign m_live_count   = live_out[COUNT_W-1:0];
    assign m_repack_due   = repack_reg;

`ifndef SYNTHESIS
    // live entries and deleted marks together never exceed the table
    a_occupancy: assert property (@(posedge aclk) disable iff (!aresetn)
        (CNT_W + 1)'(live_reg) + (CNT_W + 1)'(del_reg) <= (CNT_W + 1)'(TABLE_SLOTS))
        else $error("occupancy exceeds table size");

    // the table is written only by the clearing pass or at the end of a probe
    a_write_src: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == S_CLEAR) || (state_reg == S_PROBE && finish))
        else $error("table write outside clear or probe end");

    // a new result only follows a probe
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && $past(!m_valid_reg || m_ready)) |-> $past(state_reg) == S_PROBE)
        else $error("result without a finished probe");

    // counters move only when a probe ends
    a_counts_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_PROBE) |=> $stable(live_reg) && $stable(del_reg))
        else $error("counters changed outside a probe");
`endif

endmodule

>>> rtl/dhte_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module dhte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/dhte_probe_eval.sv
// Compare unit: judges one probed slot against the pending request.
// Depends on dhte_pkg.
module dhte_probe_eval
    import dhte_pkg::*;
(
    input  logic [OPCODE_W-1:0] opcode,
    input  logic [KEY_W-1:0]    key,
    input  logic [TAG_W-1:0]    type_tag,
    input  logic [HANDLE_W-1:0] handle,
    input  logic                load_full,
    input  slot_word_t          slot,
    output probe_dec_t          dec
);

    logic is_empty;
    logic key_hit;

    assign is_empty = (slot.kind == KIND_EMPTY);
    assign key_hit  = (slot.kind == KIND_LIVE) && (slot.key == key);

    always_comb begin
        dec           = '0;
        dec.status    = ST_MISSING;
        dec.exhausted = ST_MISSING;
        dec.wr_kind   = KIND_EMPTY;
        unique case (opcode)
            OP_FIND: begin
                if (is_empty) begin
                    dec.stop = 1'b1;
                end else if (key_hit) begin
                    dec.stop   = 1'b1;
                    dec.status = ST_OK;
                    dec.locate = 1'b1;
                    dec.report = 1'b1;
                end
            end
            OP_STORE: begin
                dec.exhausted = ST_FULL;
                if (load_full) begin
                    // load limit reached: refuse before any probe matters
                    dec.stop   = 1'b1;
                    dec.status = ST_FULL;
                end else if (is_empty) begin
                    dec.stop     = 1'b1;
                    dec.status   = ST_OK;
                    dec.locate   = 1'b1;
                    dec.wr       = 1'b1;
                    dec.wr_kind  = KIND_LIVE;
                    dec.inc_live = 1'b1;
                end else if (key_hit && (slot.tag == type_tag)) begin
                    dec.stop   = 1'b1;
                    dec.status = ST_DUP;
                    dec.locate = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (is_empty) begin
                    dec.stop = 1'b1;
                end else if (key_hit && (slot.handle == handle)) begin
                    dec.stop     = 1'b1;
                    dec.status   = ST_OK;
                    dec.locate   = 1'b1;
                    dec.wr       = 1'b1;
                    dec.wr_kind  = KIND_DELETED;
                    dec.dec_live = 1'b1;
                end
            end
            default: begin
                // unused opcode: no change, not found
                dec.stop = 1'b1;
            end
        endcase
    end

endmodule

>>> bench/tb_top.sv
// Self-checking bench for double_hash_table_engine: directed table, random traffic, then a table fill.
// Predicts results from its own copy of the slot table (typed rows give theirs); needs only dhte_pkg and the RTL.
`timescale 1ns / 100ps

module tb_top
    import dhte_pkg::*;
();

    localparam int TABLE_SLOTS  = 1024;
    localparam int POOL_SIZE    = 48;
    localparam int PHASE_ITEMS  = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int ITEM_BOUND   = 3000;
    localparam int unsigned CYCLE_LIMIT = ITEM_BOUND * (TABLE_SLOTS + 64) * 3;
    localparam int MSG_CAP      = 200;

    // Opcode left unused by the block
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic [KEY_W-1:0]    key;
        logic [TAG_W-1:0]    tag;
        logic [HANDLE_W-1:0] handle;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [SLOT_IDX_W-1:0] slot;
        logic [TAG_W-1:0]      ftype;
        logic [HANDLE_W-1:0]   fhandle;
        logic [COUNT_W-1:0]    live;
        logic                  repack;
    } outcome_t;

    typedef enum logic [1:0] {ROW_PREDICT, ROW_TYPED, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        req_t                  req;
        outcome_t              want;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
    } stim_row_t;

    // Per-phase register settings and idling
    logic [CFG_DATA_W-1:0] phase_load   [4] = '{11'd800, 11'd40, 11'd200, 11'd600};
    logic [CFG_DATA_W-1:0] phase_repack [4] = '{11'd600, 11'd20, 11'd100, 11'd300};
    int phase_send_idle  [4] = '{0, 53, 0, 21};
    int phase_recv_stall [4] = '{0, 0, 53, 21};

    // DUT signals
    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [OPCODE_W-1:0]   s_opcode = '0;
    logic [KEY_W-1:0]      s_key = '0;
    logic [TAG_W-1:0]      s_type_tag = '0;
    logic [HANDLE_W-1:0]   s_handle = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [STATUS_W-1:0]   m_status;
    logic [SLOT_IDX_W-1:0] m_slot_index;
    logic [TAG_W-1:0]      m_found_type;
    logic [HANDLE_W-1:0]   m_found_handle;
    logic [COUNT_W-1:0]    m_live_count;
    logic                  m_repack_due;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Shadow copy of the table and its registers
    logic [KIND_W-1:0]   shadow_kind   [TABLE_SLOTS];
    logic [KEY_W-1:0]    shadow_key    [TABLE_SLOTS];
    logic [TAG_W-1:0]    shadow_tag    [TABLE_SLOTS];
    logic [HANDLE_W-1:0] shadow_handle [TABLE_SLOTS];
    int                  shadow_live;
    int                  shadow_deleted;
    int                  lim_load;
    int                  lim_repack;

    outcome_t            awaited[$];
    logic [KEY_W-1:0]    key_pool [POOL_SIZE];
    int                  mismatches = 0;
    int                  results_seen = 0;
    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;
    logic                pressure_go = 1'b0;

    double_hash_table_engine #(.TABLE_SLOTS(TABLE_SLOTS)) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_key          (s_key),
        .s_type_tag     (s_type_tag),
        .s_handle       (s_handle),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_slot_index   (m_slot_index),
        .m_found_type   (m_found_type),
        .m_found_handle (m_found_handle),
        .m_live_count   (m_live_count),
        .m_repack_due   (m_repack_due),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Probe the shadow table for one request and apply its effect
    function automatic outcome_t probe_table(input req_t r);
        outcome_t              o;
        logic [SLOT_IDX_W-1:0] s;
        logic [SLOT_IDX_W-1:0] stride;
        bit                    done;
        o = '0;
        o.status = ST_MISSING;
        s = r.key[SLOT_IDX_W-1:0];
        stride = {{(SLOT_IDX_W-STRIDE_W){1'b0}}, r.key[STRIDE_LSB +: STRIDE_W]} | 1'b1;
        done = 1'b0;
        case (r.op)
            OP_FIND: begin
                for (int n = 0; n < TABLE_SLOTS && !done; n++) begin
                    if (shadow_kind[s] == KIND_EMPTY) begin
                        done = 1'b1;
                    end else if (shadow_kind[s] == KIND_LIVE && shadow_key[s] == r.key) begin
                        o.status  = ST_OK;
                        o.slot    = s;
                        o.ftype   = shadow_tag[s];
                        o.fhandle = shadow_handle[s];
                        done = 1'b1;
                    end else begin
                        s = s + stride;
                    end
                end
            end
            OP_STORE: begin
                o.status = ST_FULL;
                // load limit reached: nothing probed
                if (shadow_live < lim_load) begin
                    for (int n = 0; n < TABLE_SLOTS && !done; n++) begin
                        if (shadow_kind[s] == KIND_EMPTY) begin
                            shadow_kind[s]   = KIND_LIVE;
                            shadow_key[s]    = r.key;
                            shadow_tag[s]    = r.tag;
                            shadow_handle[s] = r.handle;
                            shadow_live++;
                            o.status = ST_OK;
                            o.slot   = s;
                            done = 1'b1;
                        end else if (shadow_kind[s] == KIND_LIVE && shadow_key[s] == r.key &&
                                     shadow_tag[s] == r.tag) begin
                            o.status = ST_DUP;
                            o.slot   = s;
                            done = 1'b1;
                        end else begin
                            s = s + stride;
                        end
                    end
                end
            end
            OP_REMOVE: begin
                for (int n = 0; n < TABLE_SLOTS && !done; n++) begin
                    if (shadow_kind[s] == KIND_EMPTY) begin
                        done = 1'b1;
                    end else if (shadow_kind[s] == KIND_LIVE && shadow_key[s] == r.key &&
                                 shadow_handle[s] == r.handle) begin
                        shadow_kind[s] = KIND_DELETED;
                        if (shadow_live > 0) shadow_live--;
                        shadow_deleted++;
                        o.status = ST_OK;
                        o.slot   = s;
                        done = 1'b1;
                    end else begin
                        s = s + stride;
                    end
                end
            end
            default: ;
        endcase
        o.live   = shadow_live[COUNT_W-1:0];
        o.repack = (shadow_deleted > lim_repack);
        return o;
    endfunction

    function automatic outcome_t result_of(input logic [STATUS_W-1:0] st,
                                           input int slot, input int ft, input int fh,
                                           input int live, input bit rp);
        outcome_t o;
        o.status  = st;
        o.slot    = SLOT_IDX_W'(slot);
        o.ftype   = TAG_W'(ft);
        o.fhandle = HANDLE_W'(fh);
        o.live    = COUNT_W'(live);
        o.repack  = rp;
        return o;
    endfunction

    function automatic stim_row_t req_row(input logic [OPCODE_W-1:0] op,
                                          input logic [KEY_W-1:0] key,
                                          input int tag, input int hdl);
        stim_row_t row;
        row.kind       = ROW_PREDICT;
        row.req.op     = op;
        row.req.key    = key;
        row.req.tag    = TAG_W'(tag);
        row.req.handle = HANDLE_W'(hdl);
        row.want       = '0;
        row.reg_idx    = '0;
        row.reg_val    = '0;
        return row;
    endfunction

    function automatic stim_row_t typed_row(input logic [OPCODE_W-1:0] op,
                                            input logic [KEY_W-1:0] key,
                                            input int tag, input int hdl,
                                            input outcome_t want);
        stim_row_t row;
        row      = req_row(op, key, tag, hdl);
        row.kind = ROW_TYPED;
        row.want = want;
        return row;
    endfunction

    function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx, input int val);
        stim_row_t row;
        row         = req_row(OP_FIND, '0, 0, 0);
        row.kind    = ROW_CFG;
        row.reg_idx = idx;
        row.reg_val = CFG_DATA_W'(val);
        return row;
    endfunction

    // Random live slot, or -1 when the table holds none
    function automatic int pick_live_slot();
        int start;
        int hit;
        start = $urandom_range(0, TABLE_SLOTS - 1);
        hit = -1;
        for (int n = 0; n < TABLE_SLOTS && hit < 0; n++) begin
            if (shadow_kind[(start + n) % TABLE_SLOTS] == KIND_LIVE)
                hit = (start + n) % TABLE_SLOTS;
        end
        return hit;
    endfunction

    // Mostly requests aimed at live entries and colliding keys, some noise
    function automatic req_t random_request();
        req_t r;
        int   roll;
        int   s;
        roll = $urandom_range(0, 99);
        s = pick_live_slot();
        r.key = ($urandom_range(0, 4) != 0) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                            : {$urandom, $urandom};
        r.tag = ($urandom_range(0, 9) < 7) ? TAG_W'($urandom_range(0, 3)) : TAG_W'($urandom);
        r.handle = HANDLE_W'($urandom);
        if (roll < 36) begin
            r.op = OP_STORE;
            // resend a live entry now and then to hit the duplicate path
            if (s >= 0 && $urandom_range(0, 9) == 0) begin
                r.key = shadow_key[s];
                r.tag = shadow_tag[s];
            end
        end else if (roll < 66) begin
            r.op = OP_FIND;
            if (s >= 0 && $urandom_range(0, 9) < 6) r.key = shadow_key[s];
        end else if (roll < 96) begin
            r.op = OP_REMOVE;
            if (s >= 0 && $urandom_range(0, 9) < 8) begin
                r.key = shadow_key[s];
                if ($urandom_range(0, 9) < 7) r.handle = shadow_handle[s];
            end
        end else begin
            r.op = OP_UNUSED;
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        mismatches++;
        // keep the log readable if everything goes wrong
        if (mismatches <= MSG_CAP)
            $display("MISMATCH result %0d %s: got %0h expected %0h",
                     results_seen, what, got, want);
    endtask

    // Offer one request and hold it until taken
    task automatic issue(input req_t r);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_opcode   <= r.op;
        s_key      <= r.key;
        s_type_tag <= r.tag;
        s_handle   <= r.handle;
        do @(posedge aclk); while (s_ready !== 1'b1);
    endtask

    task automatic submit(input req_t r, input bit typed, input outcome_t want,
                          output outcome_t calc);
        issue(r);
        calc = probe_table(r);
        awaited.push_back(typed ? want : calc);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (awaited.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        drain();
        repeat (2) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_LOAD_LIMIT) lim_load = val;
        else lim_repack = val;
    endtask

    // Result side: random stalls, plus one long hold-off to back the block up
    initial begin : result_sink
        bit held;
        int waited;
        held = 1'b0;
        forever begin
            @(posedge aclk);
            if (pressure_go && !held) begin
                held = 1'b1;
                m_ready <= 1'b0;
                for (waited = 0; waited < HOLD_CYCLES; waited++) @(posedge aclk);
            end
            m_ready <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Compare every accepted result with the oldest expectation
    always @(posedge aclk) begin : result_check
        outcome_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (awaited.size() == 0) begin
                flag_mismatch("result with nothing outstanding", m_status, '0);
            end else begin
                want = awaited.pop_front();
                if (m_status !== want.status)
                    flag_mismatch("status", m_status, want.status);
                if (m_slot_index !== want.slot)
                    flag_mismatch("slot_index", m_slot_index, want.slot);
                if (m_found_type !== want.ftype)
                    flag_mismatch("found_type", m_found_type, want.ftype);
                if (m_found_handle !== want.fhandle)
                    flag_mismatch("found_handle", m_found_handle, want.fhandle);
                if (m_live_count !== want.live)
                    flag_mismatch("live_count", m_live_count, want.live);
                if (m_repack_due !== want.repack)
                    flag_mismatch("repack_due", m_repack_due, want.repack);
            end
            results_seen++;
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        stim_row_t plan[$];
        req_t      r;
        outcome_t  calc;
        int        made;
        int        full_seen;
        int        fill_n;

        for (int i = 0; i < TABLE_SLOTS; i++) begin
            shadow_kind[i]   = KIND_EMPTY;
            shadow_key[i]    = '0;
            shadow_tag[i]    = '0;
            shadow_handle[i] = '0;
        end
        shadow_live    = 0;
        shadow_deleted = 0;
        lim_load       = LOAD_LIMIT_RESET;
        lim_repack     = REPACK_LIMIT_RESET;

        // Key pool: some keys share a home slot, some the whole probe path
        for (int i = 0; i < POOL_SIZE; i++) begin
            key_pool[i] = {$urandom, $urandom};
            if (i % 4 == 1) key_pool[i][16:0] = {8'h00, 9'(i % 3) * 9'd5};
            if (i % 4 == 2) key_pool[i][9:0] = (i % 8 == 2) ? 10'd1023 : 10'd512;
        end

        // Directed rows
        plan.push_back(typed_row(OP_FIND, 64'h0, 0, 0, result_of(ST_MISSING, 0, 0, 0, 0, 0)));
        plan.push_back(typed_row(OP_UNUSED, '1, 8'hff, 16'hffff,
                                 result_of(ST_MISSING, 0, 0, 0, 0, 0)));
        plan.push_back(typed_row(OP_STORE, 64'h0, 0, 0, result_of(ST_OK, 0, 0, 0, 1, 0)));
        plan.push_back(typed_row(OP_STORE, 64'h0, 0, 1, result_of(ST_DUP, 0, 0, 0, 1, 0)));
        plan.push_back(req_row(OP_STORE, 64'h0, 8'hff, 16'hffff));
        plan.push_back(typed_row(OP_FIND, 64'h0, 0, 0, result_of(ST_OK, 0, 0, 0, 2, 0)));
        plan.push_back(typed_row(OP_STORE, '1, 8'hff, 16'hffff,
                                 result_of(ST_OK, 1023, 0, 0, 3, 0)));
        plan.push_back(typed_row(OP_FIND, '1, 0, 0,
                                 result_of(ST_OK, 1023, 8'hff, 16'hffff, 3, 0)));
        plan.push_back(req_row(OP_REMOVE, 64'h0, 0, 16'hffff));
        // same remove again: probe passes the deleted mark and misses
        plan.push_back(req_row(OP_REMOVE, 64'h0, 0, 16'hffff));
        plan.push_back(req_row(OP_STORE, 64'h400, 1, 5));
        plan.push_back(req_row(OP_REMOVE, 64'h400, 1, 4));
        // home slot holds a deleted mark: store goes on to the next empty one
        plan.push_back(req_row(OP_STORE, 64'h0001_0000_0000_0001, 2, 6));
        plan.push_back(req_row(OP_FIND, 64'h0001_0000_0000_0001, 0, 0));
        plan.push_back(req_row(OP_FIND, 64'h8000_0000_0000_0000, 0, 0));
        plan.push_back(reg_row(REG_LOAD_LIMIT, 0));
        plan.push_back(typed_row(OP_STORE, 64'h1234, 3, 7, result_of(ST_FULL, 0, 0, 0, 4, 0)));
        plan.push_back(reg_row(REG_REPACK_LIMIT, 0));
        plan.push_back(req_row(OP_FIND, 64'h0001_0000_0000_0001, 0, 0));
        plan.push_back(reg_row(REG_LOAD_LIMIT, 4));
        plan.push_back(req_row(OP_STORE, 64'h1234, 3, 7));
        plan.push_back(req_row(OP_REMOVE, '1, 0, 16'hffff));
        plan.push_back(req_row(OP_STORE, 64'h1234, 3, 7));
        plan.push_back(reg_row(REG_LOAD_LIMIT, 1024));
        plan.push_back(reg_row(REG_REPACK_LIMIT, 1024));
        plan.push_back(req_row(OP_STORE, 64'h1234, 3, 8));

        // Reset, then wait out the clearing pass
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        do @(posedge aclk); while (s_ready !== 1'b1);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG)
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            else
                submit(plan[i].req, plan[i].kind == ROW_TYPED, plan[i].want, calc);
        end

        // Random phases, one register setting and idling pattern each
        for (int p = 0; p < 4; p++) begin
            write_reg(REG_LOAD_LIMIT, phase_load[p]);
            write_reg(REG_REPACK_LIMIT, phase_repack[p]);
            send_idle_pct  = phase_send_idle[p];
            recv_stall_pct = phase_recv_stall[p];
            if (p == 2) pressure_go <= 1'b1;
            made = 0;
            while (made < PHASE_ITEMS) begin
                r = random_request();
                submit(r, 1'b0, '0, calc);
                if (r.op != OP_UNUSED) made++;
            end
        end

        // Fill the table until stores run out of empty slots
        write_reg(REG_LOAD_LIMIT, 1024);
        write_reg(REG_REPACK_LIMIT, 1024);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        full_seen = 0;
        fill_n = 0;
        while (full_seen < 4 && fill_n < 2 * TABLE_SLOTS) begin
            r.op     = OP_STORE;
            r.key    = {$urandom, $urandom};
            r.key[9:0] = fill_n[9:0];
            r.tag    = TAG_W'($urandom);
            r.handle = HANDLE_W'($urandom);
            submit(r, 1'b0, '0, calc);
            if (calc.status == ST_FULL) full_seen++;
            fill_n++;
        end
        // full table: misses walk every slot
        repeat (2) begin
            r.op     = OP_FIND;
            r.key    = {$urandom, $urandom};
            r.tag    = '0;
            r.handle = '0;
            submit(r, 1'b0, '0, calc);
        end
        repeat (10) begin
            r = random_request();
            submit(r, 1'b0, '0, calc);
        end

        drain();
        repeat (TABLE_SLOTS + 8) @(posedge aclk);
        if (mismatches == 0 && awaited.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
